[rtl/mspm_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mspm_pkg
// Shared types and constants of the multirate step plan merger.
// ---------------------------------------------------------------------------
package mspm_pkg;

  localparam int MAX_CLUSTERS_DEF = 16;
  localparam int TIME_WIDTH_DEF   = 32;
  localparam int STEP_W           = 32;
  localparam int IDX_OUT_W        = 4;

  // request commands
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_FETCH  = 2'd2;

  // action phases, in sort order
  localparam logic [1:0] PH_CORR = 2'd0;
  localparam logic [1:0] PH_PRED = 2'd1;
  localparam logic [1:0] PH_FACE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_READ,
    ST_UPDATE,
    ST_EMPTY
  } mspm_state_t;

  typedef struct packed {
    logic vld;
    logic first;
  } mspm_scan_ctrl_t;

  typedef struct packed {
    logic found;
    logic is_corr;
  } mspm_scan_res_t;

endpackage

[rtl/mspm_table.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mspm_table
// Cluster table: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module mspm_table #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 194
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/mspm_scan.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mspm_scan
// Min-key search over entries streamed from the table, one per cycle.
// ---------------------------------------------------------------------------
module mspm_scan #(
  parameter int TW = 32,
  parameter int CW = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mspm_pkg::mspm_scan_ctrl_t     ctrl,
  input  logic [CW-1:0]                 idx,
  input  logic                          high,
  input  logic                          face,
  input  logic [TW-1:0]                 rate,
  input  logic [TW-1:0]                 sync,
  input  logic [TW-1:0]                 pstart,
  input  logic [TW-1:0]                 cstart,
  output logic                          busy,
  output mspm_pkg::mspm_scan_res_t      res,
  output logic [CW-1:0]                 best_idx
);
  import mspm_pkg::*;

  localparam int KW = TW + 3 + CW;

  // stage 2: correction end time and stream liveness
  mspm_scan_ctrl_t s2_ctrl_r;
  logic            s2_pv_r, s2_cv_r, s2_face_r, s2_prio_r;
  logic [TW-1:0]   s2_pstart_r, s2_cstart_r, s2_cend_r;
  logic [CW-1:0]   s2_idx_r;

  // stage 3: best candidate of one entry
  mspm_scan_ctrl_t s3_ctrl_r;
  logic            s3_v_r, s3_corr_r;
  logic [KW-1:0]   s3_key_r;

  // running best
  logic            found_r, corr_r;
  logic [KW-1:0]   best_r;

  logic [TW:0]     csum;
  logic [TW-1:0]   csat, cend;
  logic [KW-1:0]   pkey, ckey;
  logic            pick_pred;

  always_comb begin
    csum = {1'b0, cstart} + {1'b0, rate};
    csat = csum[TW] ? {TW{1'b1}} : csum[TW-1:0];
    cend = (csat < sync) ? csat : sync;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctrl_r <= '0;
    end else begin
      s2_ctrl_r <= ctrl;
    end
    s2_pv_r     <= pstart < sync;
    s2_cv_r     <= cstart < sync;
    s2_face_r   <= face;
    s2_prio_r   <= ~high;
    s2_pstart_r <= pstart;
    s2_cstart_r <= cstart;
    s2_cend_r   <= cend;
    s2_idx_r    <= idx;
  end

  always_comb begin
    pkey = {s2_pstart_r, PH_PRED, s2_prio_r, s2_idx_r};
    if (s2_face_r) begin
      ckey = {s2_cstart_r, PH_FACE, s2_prio_r, s2_idx_r};
    end else begin
      ckey = {s2_cend_r, PH_CORR, s2_prio_r, s2_idx_r};
    end
    pick_pred = s2_pv_r && (!s2_cv_r || (pkey < ckey));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctrl_r <= '0;
    end else begin
      s3_ctrl_r <= s2_ctrl_r;
    end
    s3_v_r    <= s2_pv_r || s2_cv_r;
    s3_corr_r <= !pick_pred;
    s3_key_r  <= pick_pred ? pkey : ckey;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      corr_r  <= 1'b0;
    end else if (s3_ctrl_r.vld) begin
      if (s3_v_r && (s3_ctrl_r.first || !found_r || (s3_key_r < best_r))) begin
        found_r <= 1'b1;
        corr_r  <= s3_corr_r;
      end else if (s3_ctrl_r.first) begin
        found_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ctrl_r.vld && s3_v_r &&
        (s3_ctrl_r.first || !found_r || (s3_key_r < best_r))) begin
      best_r <= s3_key_r;
    end
  end

  assign busy        = s2_ctrl_r.vld || s3_ctrl_r.vld;
  assign res.found   = found_r;
  assign res.is_corr = corr_r;
  assign best_idx    = best_r[CW-1:0];

endmodule

[rtl/multirate_step_plan_merger_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multirate_step_plan_merger_unit
// Merges per-cluster predict/correct streams into one sorted action plan.
// ---------------------------------------------------------------------------
// Clear and append requests are carried out as they are taken. A fetch reads
// the cluster table one entry per cycle through a three-stage min-key search,
// then reads the winning entry again and writes its advanced cursor back; when
// no action is left, it answers with an empty result instead. With an empty
// table a fetch answers without a search. The next request can be taken once
// the result is in the output register. One request is in flight at a time; a
// finished result sits in the output register while the next request is taken.
module multirate_step_plan_merger_unit #(
  parameter int MAX_CLUSTERS = mspm_pkg::MAX_CLUSTERS_DEF,
  parameter int TIME_WIDTH   = mspm_pkg::TIME_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [0] high_priority, [1] face_after_correction, [33:2] rate,
  // [65:34] steps_until_sync, [71:66] zero
  input  logic [71:0] in_tdata,
  // [1:0] cmd
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] valid_res, [4:1] cluster_index, [5] is_correct, [37:6] step_index,
  // [39:38] zero
  output logic [39:0] out_tdata
);
  import mspm_pkg::*;

  localparam int TW  = TIME_WIDTH;
  localparam int CW  = $clog2(MAX_CLUSTERS);
  localparam int NW  = $clog2(MAX_CLUSTERS + 1);
  localparam int EW  = 4 * TW + 2 * STEP_W + 2;
  // entry layout, low bits first
  localparam int O_CST  = 0;
  localparam int O_CSP  = TW;
  localparam int O_PST  = TW + STEP_W;
  localparam int O_PSP  = 2 * TW + STEP_W;
  localparam int O_SYN  = 2 * TW + 2 * STEP_W;
  localparam int O_RAT  = 3 * TW + 2 * STEP_W;
  localparam int O_FACE = 4 * TW + 2 * STEP_W;
  localparam int O_HIGH = 4 * TW + 2 * STEP_W + 1;

  mspm_state_t     state_r, state_nxt;
  logic [NW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   ptr_r, ptr_nxt;
  logic            out_tvalid_r, out_tvalid_nxt;
  logic [39:0]     out_tdata_r, out_tdata_nxt;
  mspm_scan_ctrl_t rd_ctrl_r, rd_ctrl_nxt;
  logic [CW-1:0]   rd_idx_r;

  logic            mem_we;
  logic [CW-1:0]   mem_waddr, mem_raddr;
  logic [EW-1:0]   mem_wdata, mem_rdata;

  logic            scan_busy;
  mspm_scan_res_t  scan_res;
  logic [CW-1:0]   best_idx;

  logic            accept, slot_free;
  logic [1:0]      cmd;
  logic [TW+31:0]  rate_wide, sync_wide;
  logic [TW-1:0]   rate_in, sync_in;
  logic [TW-1:0]   e_rate, e_start;
  logic [STEP_W-1:0] e_step;
  logic [TW:0]     upd_sum;
  logic [TW-1:0]   upd_start;
  logic [CW+IDX_OUT_W-1:0] idx_wide;

  assign accept    = in_tvalid && in_tready;
  assign cmd       = in_tuser;
  assign slot_free = !out_tvalid_r || out_tready;

  always_comb begin
    rate_wide = {{TW{1'b0}}, in_tdata[33:2]};
    sync_wide = {{TW{1'b0}}, in_tdata[65:34]};
    rate_in   = (rate_wide[TW-1:0] == '0) ? TW'(1) : rate_wide[TW-1:0];
    sync_in   = sync_wide[TW-1:0];
  end

  // cursor of the winning stream
  always_comb begin
    e_rate    = mem_rdata[O_RAT +: TW];
    e_start   = scan_res.is_corr ? mem_rdata[O_CST +: TW] : mem_rdata[O_PST +: TW];
    e_step    = scan_res.is_corr ? mem_rdata[O_CSP +: STEP_W] :
                                   mem_rdata[O_PSP +: STEP_W];
    upd_sum   = {1'b0, e_start} + {1'b0, e_rate};
    upd_start = upd_sum[TW] ? {TW{1'b1}} : upd_sum[TW-1:0];
    idx_wide  = {{IDX_OUT_W{1'b0}}, best_idx};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
      rd_ctrl_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      rd_ctrl_r    <= rd_ctrl_nxt;
    end
    ptr_r       <= ptr_nxt;
    rd_idx_r    <= ptr_r;
    out_tdata_r <= out_tdata_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    rd_ctrl_nxt    = '0;
    mem_we         = 1'b0;
    mem_waddr      = count_r[CW-1:0];
    mem_wdata      = {in_tdata[0], in_tdata[1], rate_in, sync_in,
                      {STEP_W{1'b0}}, {TW{1'b0}}, {STEP_W{1'b0}}, {TW{1'b0}}};
    mem_raddr      = best_idx;
    in_tready      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        ptr_nxt   = '0;
        if (accept) begin
          case (cmd)
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            CMD_APPEND: begin
              if (count_r < NW'(MAX_CLUSTERS)) begin
                mem_we    = 1'b1;
                count_nxt = count_r + NW'(1);
              end
            end
            CMD_FETCH: begin
              state_nxt = (count_r == '0) ? ST_EMPTY : ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        mem_raddr         = ptr_r;
        rd_ctrl_nxt.vld   = 1'b1;
        rd_ctrl_nxt.first = (ptr_r == '0);
        ptr_nxt           = ptr_r + CW'(1);
        if (NW'(ptr_r) + NW'(1) == count_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_ctrl_r.vld && !scan_busy) begin
          state_nxt = scan_res.found ? ST_READ : ST_EMPTY;
        end
      end
      ST_READ: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        // read data stays valid: the address is held on best_idx
        if (slot_free) begin
          mem_we    = 1'b1;
          mem_waddr = best_idx;
          mem_wdata = mem_rdata;
          if (scan_res.is_corr) begin
            mem_wdata[O_CST +: TW]     = upd_start;
            mem_wdata[O_CSP +: STEP_W] = e_step + STEP_W'(1);
          end else begin
            mem_wdata[O_PST +: TW]     = upd_start;
            mem_wdata[O_PSP +: STEP_W] = e_step + STEP_W'(1);
          end
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {2'b00, e_step, scan_res.is_corr,
                            idx_wide[IDX_OUT_W-1:0], 1'b1};
          state_nxt      = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = '0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  mspm_table #(
    .DEPTH (MAX_CLUSTERS),
    .WIDTH (EW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  mspm_scan #(
    .TW (TW),
    .CW (CW)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (rd_ctrl_r),
    .idx      (rd_idx_r),
    .high     (mem_rdata[O_HIGH]),
    .face     (mem_rdata[O_FACE]),
    .rate     (mem_rdata[O_RAT +: TW]),
    .sync     (mem_rdata[O_SYN +: TW]),
    .pstart   (mem_rdata[O_PST +: TW]),
    .cstart   (mem_rdata[O_CST +: TW]),
    .busy     (scan_busy),
    .res      (scan_res),
    .best_idx (best_idx)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_tdata_r[0] |-> out_tdata_r[39:1] == '0)
    else $error("exhausted result carries nonzero fields");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(MAX_CLUSTERS))
    else $error("cluster count above capacity");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN || state_r == ST_DRAIN || state_r == ST_READ) |-> !mem_we)
    else $error("table written during search");

  a_result_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) && slot_free |=> out_tvalid_r && out_tdata_r[0])
    else $error("update did not present a valid action");

endmodule

[tb/tb_multirate_step_plan_merger_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_multirate_step_plan_merger_unit
// Drives clear, append and fetch requests into the plan merger and checks
// every fetched action against a local cluster-table predictor or a fixed
// value. A short directed table covers the corner cases, then random table
// builds and fetch runs follow, with random gaps and stalls on both streams.
// ---------------------------------------------------------------------------
module tb_multirate_step_plan_merger_unit;
  import mspm_pkg::*;

  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int          TAB_DEPTH   = MAX_CLUSTERS_DEF;
  localparam logic [63:0] TIME_MAX    = 64'h0000_0000_FFFF_FFFF;
  localparam int          ITEM_TARGET = 450;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_WAIT  = 40;
  localparam int          CYCLE_LIMIT = 300000;
  localparam int          DIR_N       = 24;

  typedef struct packed {
    logic        valid_res;
    logic [3:0]  cluster_index;
    logic        is_correct;
    logic [31:0] step_index;
  } action_t;

  localparam action_t NO_ACTION = '0;

  typedef struct {
    logic [1:0]  cmd;
    logic        hp;
    logic        face;
    logic [31:0] rate;
    logic [31:0] sync;
    bit          typed;
    action_t     exp;
  } plan_req_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  multirate_step_plan_merger_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // cluster table copy
  int unsigned tab_count;
  bit          tab_hp     [TAB_DEPTH];
  bit          tab_face   [TAB_DEPTH];
  logic [63:0] tab_rate   [TAB_DEPTH];
  logic [63:0] tab_sync   [TAB_DEPTH];
  logic [31:0] pred_step  [TAB_DEPTH];
  logic [63:0] pred_start [TAB_DEPTH];
  logic [31:0] corr_step  [TAB_DEPTH];
  logic [63:0] corr_start [TAB_DEPTH];

  action_t     action_q [$];
  action_t     due;
  int unsigned mism_cnt;
  int unsigned cycle_cnt;
  int unsigned n_items;
  bit          idle_en;
  bit          hold_req;
  plan_req_t   dir_tab [DIR_N];

  function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
    if (a > TIME_MAX || b > TIME_MAX - a) return TIME_MAX;
    return a + b;
  endfunction

  // smallest live key over all predict and correct cursors; key packs
  // (time, phase, low-priority bit, cluster) so a plain compare sorts it
  function automatic action_t next_action();
    logic [71:0] best;
    logic [71:0] k;
    logic [63:0] e;
    bit          found;
    bit          best_corr;
    int          i;
    int          w;
    action_t     a;
    found = 0;
    best_corr = 0;
    best = '0;
    for (i = 0; i < tab_count; i++) begin
      if (pred_start[i] < tab_sync[i]) begin
        k = {pred_start[i], PH_PRED, ~tab_hp[i], 5'(i)};
        if (!found || k < best) begin
          best = k;
          best_corr = 0;
          found = 1;
        end
      end
      if (corr_start[i] < tab_sync[i]) begin
        if (tab_face[i]) begin
          k = {corr_start[i], PH_FACE, ~tab_hp[i], 5'(i)};
        end else begin
          e = sat_sum(corr_start[i], tab_rate[i]);
          k = {(e < tab_sync[i]) ? e : tab_sync[i], PH_CORR, ~tab_hp[i], 5'(i)};
        end
        if (!found || k < best) begin
          best = k;
          best_corr = 1;
          found = 1;
        end
      end
    end
    if (!found) return NO_ACTION;
    w = int'(best[4:0]);
    a.valid_res = 1'b1;
    a.cluster_index = best[3:0];
    a.is_correct = best_corr;
    if (best_corr) begin
      a.step_index = corr_step[w];
      corr_step[w] = corr_step[w] + 32'd1;
      corr_start[w] = sat_sum(corr_start[w], tab_rate[w]);
    end else begin
      a.step_index = pred_step[w];
      pred_step[w] = pred_step[w] + 32'd1;
      pred_start[w] = sat_sum(pred_start[w], tab_rate[w]);
    end
    return a;
  endfunction

  // update the table copy, queue the expected action, then offer the request
  task automatic issue_request(input plan_req_t r, output action_t act);
    int unsigned gap;
    act = NO_ACTION;
    case (r.cmd)
      CMD_CLEAR: tab_count = 0;
      CMD_APPEND: begin
        if (tab_count < TAB_DEPTH) begin
          tab_hp[tab_count]     = r.hp;
          tab_face[tab_count]   = r.face;
          tab_rate[tab_count]   = (r.rate == 32'd0) ? 64'd1 : {32'd0, r.rate};
          tab_sync[tab_count]   = {32'd0, r.sync};
          pred_step[tab_count]  = '0;
          pred_start[tab_count] = '0;
          corr_step[tab_count]  = '0;
          corr_start[tab_count] = '0;
          tab_count++;
        end
      end
      CMD_FETCH: begin
        act = next_action();
        action_q = {action_q, (r.typed ? r.exp : act)};
      end
      default: ;
    endcase
    if (r.cmd != CMD_UNUSED) n_items++;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.cmd;
    in_tdata  <= {6'd0, r.sync, r.rate, r.face, r.hp};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(0, 11))
      0:       return $urandom;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000 | $urandom_range(0, 3);
      3:       return 32'd0;
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic logic [31:0] pick_sync();
    case ($urandom_range(0, 11))
      0:       return $urandom;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd0;
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  function automatic plan_req_t rand_append();
    plan_req_t r;
    r.cmd   = CMD_APPEND;
    r.hp    = $urandom_range(0, 1);
    r.face  = $urandom_range(0, 1);
    r.rate  = pick_rate();
    r.sync  = pick_sync();
    r.typed = 0;
    r.exp   = NO_ACTION;
    return r;
  endfunction

  function automatic plan_req_t plain_req(input logic [1:0] cmd);
    plan_req_t r;
    r.cmd   = cmd;
    r.hp    = $urandom_range(0, 1);
    r.face  = $urandom_range(0, 1);
    r.rate  = $urandom;
    r.sync  = $urandom;
    r.typed = 0;
    r.exp   = NO_ACTION;
    return r;
  endfunction

  // stimulus
  initial begin
    action_t act;
    int      n_app;
    int      budget;
    int      empties;
    int      pick;
    bit      hold_fired;
    bit      drained;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_CLEAR;
    tab_count = 0;
    n_items   = 0;
    mism_cnt  = 0;
    idle_en   = 1;
    hold_req  = 0;
    hold_fired = 0;
    drained   = 0;
    dir_tab = '{
      '{CMD_FETCH,  1'b0, 1'b0, 32'h0, 32'h0, 1'b1, NO_ACTION},   // empty after reset
      '{CMD_UNUSED, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_ACTION},
      '{CMD_APPEND, 1'b1, 1'b0, 32'h0, 32'd2, 1'b0, NO_ACTION},   // zero rate
      '{CMD_APPEND, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_ACTION},
      '{CMD_APPEND, 1'b0, 1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, NO_ACTION},
      '{CMD_APPEND, 1'b1, 1'b1, 32'd3, 32'd0, 1'b0, NO_ACTION},   // no steps
      '{CMD_FETCH,  1'b0, 1'b0, 32'h0, 32'h0, 1'b1, {1'b1, 4'd0, 1'b0, 32'd0}},
      '{CMD_FETCH,  1'b0, 1'b0, 32'h0, 32'h0, 1'b0, NO_ACTION},
      '{CMD_FETCH,  1'b0, 1'b0, 32'h0, 32'h0, 1'b0, NO_ACTION},
      '{CMD_FETCH,  1'b0, 1'b0, 32'h0, 32'h0, 1'b0, NO_ACTION},
      '{CMD_FETCH,  1'b0, 1'b0, 32'h0, 32'h0, 1'b0, NO_ACTION},
      '{CMD_FETCH,  1'b0, 1'b0, 32'h0, 32'h0, 1'b0, NO_ACTION},
      '{CMD_FETCH,  1'b0, 1'b0, 32'h0, 32'h0, 1'b0, NO_ACTION},
      '{CMD_FETCH,  1'b0, 1'b0, 32'h0, 32'h0, 1'b0, NO_ACTION},
      '{CMD_FETCH,  1'b0, 1'b0, 32'h0, 32'h0, 1'b0, NO_ACTION},
      '{CMD_FETCH,  1'b0, 1'b0, 32'h0, 32'h0, 1'b0, NO_ACTION},
      '{CMD_FETCH,  1'b0, 1'b0, 32'h0, 32'h0, 1'b1, NO_ACTION},   // saturated, exhausted
      '{CMD_CLEAR,  1'b0, 1'b0, 32'h0, 32'h0, 1'b0, NO_ACTION},
      '{CMD_FETCH,  1'b0, 1'b0, 32'h0, 32'h0, 1'b1, NO_ACTION},
      '{CMD_APPEND, 1'b0, 1'b0, 32'd5, 32'd12, 1'b0, NO_ACTION},
      '{CMD_FETCH,  1'b0, 1'b0, 32'h0, 32'h0, 1'b1, {1'b1, 4'd0, 1'b0, 32'd0}},
      '{CMD_APPEND, 1'b1, 1'b1, 32'd4, 32'd8, 1'b0, NO_ACTION},   // late append
      '{CMD_FETCH,  1'b0, 1'b0, 32'h0, 32'h0, 1'b0, NO_ACTION},
      '{CMD_FETCH,  1'b0, 1'b0, 32'h0, 32'h0, 1'b0, NO_ACTION}
    };
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) issue_request(dir_tab[i], act);

    while (n_items < ITEM_TARGET) begin
      idle_en = (n_items % 120 < 90) && (n_items < ITEM_TARGET - 60);
      if (!hold_fired && n_items > 150) begin
        hold_fired = 1;
        hold_req = 1;
      end
      if (!drained && n_items > 300) begin
        drained = 1;
        // stop offering so the last request is not taken twice
        @(negedge clk);
        in_tvalid <= 1'b0;
        while (action_q.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 3) != 0) issue_request(plain_req(CMD_CLEAR), act);
      n_app = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
      repeat (n_app) issue_request(rand_append(), act);
      budget = $urandom_range(4, 60);
      empties = 0;
      while (budget > 0 && empties < 2) begin
        pick = $urandom_range(0, 29);
        if (pick == 0) begin
          issue_request(rand_append(), act);
        end else if (pick == 1) begin
          issue_request(plain_req(CMD_UNUSED), act);
        end else begin
          issue_request(plain_req(CMD_FETCH), act);
          if (!act.valid_res) empties++;
        end
        budget--;
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (action_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mism_cnt == 0) begin
      $display("** multirate_step_plan_merger_unit: PASSED **");
    end else begin
      $display("** multirate_step_plan_merger_unit: FAILED **");
    end
    $finish;
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    int unsigned gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        gap = $urandom_range(1, 12);
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (action_q.size() == 0) begin
        mism_cnt++;
        if (mism_cnt <= 10)
          $display("unexpected result %h at %0t", out_tdata, $realtime);
      end else begin
        due = action_q.pop_front();
        if (out_tdata[0] !== due.valid_res || out_tdata[4:1] !== due.cluster_index ||
            out_tdata[5] !== due.is_correct || out_tdata[37:6] !== due.step_index) begin
          mism_cnt++;
          if (mism_cnt <= 10)
            $display("mismatch at %0t: exp vld=%0d cl=%0d corr=%0d step=%0d,",
                     $realtime, due.valid_res, due.cluster_index, due.is_correct,
                     due.step_index,
                     " got vld=%0d cl=%0d corr=%0d step=%0d",
                     out_tdata[0], out_tdata[4:1], out_tdata[5], out_tdata[37:6]);
        end
      end
    end
  end

  initial cycle_cnt = 0;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("** multirate_step_plan_merger_unit: FAILED **");
      $finish;
    end
  end

endmodule

[filelist.f]
rtl/mspm_pkg.sv
rtl/mspm_table.sv
rtl/mspm_scan.sv
rtl/multirate_step_plan_merger_unit.sv
tb/tb_multirate_step_plan_merger_unit.sv
